/* rtl/core/mad_pkg.sv */
package mad_pkg;

	// field widths
	localparam int X_W    = 32;
	localparam int Y_W    = 32;
	localparam int IDX_W  = 24;
	localparam int DEV_W  = 33;
	localparam int WS_W   = 11;

	// datapath widths
	localparam int SUM_W  = 43;   // sum of up to 2047 samples
	localparam int NUM_W  = 44;   // y * W - window sum
	localparam int DSUM_W = 57;   // deviation sum, also the divider shift register
	localparam int CNT_W  = 24;
	localparam int DVR_W  = 24;   // divisor: window size or point count

	localparam int DEV_ITER   = NUM_W;
	localparam int MEAN_ITER  = DSUM_W;
	localparam int DIV_CNT_W  = $clog2(DSUM_W + 1);

	localparam int WS_RESET_I = 16;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ABSOLUTE_MODE = 1'b1;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef logic signed [Y_W-1:0]   sample_t;
	typedef logic signed [SUM_W-1:0] wsum_t;
	typedef logic [CNT_W-1:0]        count_t;
	typedef logic signed [DEV_W-1:0] dev_t;

endpackage

/* rtl/core/mad_ram.sv */
module mad_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/core/moving_average_deviation_core.sv */
// Channel   Handshake              Payload
// in        in_valid / in_ready    sample_x, sample_y, last_sample
// out       out_valid / out_ready  item_x, item_y, item_index, deviation, end_of_run,
//                                  mean_deviation, mean_valid
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An accepted sample passes S_MUL, S_PREP, S_DIV and S_POST before its result is registered:
// the restoring divider retires one quotient bit per cycle over a 44-bit dividend.
// A run's last sample adds the S_MPREP state and, if any counted, the 57-bit mean division.
// Reset clears run state; window store entries older than the run read as zero by fill count.
// The output register frees the input side while a result waits; a stalled output holds
// the next result in its final state until the register is taken.
module moving_average_deviation_core #(
	parameter int MAX_WINDOW = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [mad_pkg::X_W-1:0]              sample_x,
	input  logic signed [mad_pkg::Y_W-1:0]       sample_y,
	input  logic                                 last_sample,

	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [mad_pkg::X_W-1:0]              item_x,
	output logic signed [mad_pkg::Y_W-1:0]       item_y,
	output logic [mad_pkg::IDX_W-1:0]            item_index,
	output logic signed [mad_pkg::DEV_W-1:0]     deviation,
	output logic                                 end_of_run,
	output logic signed [mad_pkg::DEV_W-1:0]     mean_deviation,
	output logic                                 mean_valid,

	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mad_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mad_pkg::WS_W-1:0]             cfg_data
);

	localparam int AW = $clog2(MAX_WINDOW);
	localparam int PW = AW + 1;
	localparam logic [PW-1:0] MAX_P    = PW'(MAX_WINDOW);
	localparam logic [AW-1:0] LAST_POS = AW'(MAX_WINDOW - 1);
	localparam int W_RESET_I = (MAX_WINDOW < mad_pkg::WS_RESET_I) ? MAX_WINDOW
		: mad_pkg::WS_RESET_I;
	localparam int PAD_W = mad_pkg::DSUM_W - mad_pkg::NUM_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_PREP  = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_POST  = 3'd4;
	localparam logic [2:0] S_MPREP = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	// control state
	logic [2:0]                           state_q;
	logic                                 out_valid_q;
	logic [mad_pkg::WS_W-1:0]             w_eff_q;
	logic                                 abs_q;
	mad_pkg::wsum_t                       wsum_q;
	mad_pkg::count_t                      scnt_q;
	logic [mad_pkg::DSUM_W-1:0]           dsum_q;
	mad_pkg::count_t                      pc_q;
	logic [AW-1:0]                        wr_pos_q;
	logic [mad_pkg::DIV_CNT_W-1:0]        cnt_q;
	logic                                 mean_phase_q;

	// payload
	logic [mad_pkg::X_W-1:0]              x_q;
	mad_pkg::sample_t                     y_q;
	logic                                 last_q;
	mad_pkg::count_t                      idx_q;
	logic signed [mad_pkg::NUM_W-1:0]     num_q;
	logic                                 neg_q;
	logic [mad_pkg::DSUM_W-1:0]           dvd_q;
	logic [mad_pkg::DVR_W-1:0]            dvr_q;
	logic [mad_pkg::DVR_W-1:0]            rem_q;
	mad_pkg::dev_t                        dev_q;

	logic [mad_pkg::X_W-1:0]              item_x_q;
	mad_pkg::sample_t                     item_y_q;
	mad_pkg::count_t                      item_index_q;
	mad_pkg::dev_t                        deviation_q;
	logic                                 end_of_run_q;
	mad_pkg::dev_t                        mean_deviation_q;
	logic                                 mean_valid_q;

	logic                                 in_acc;
	logic                                 cfg_acc;
	logic                                 out_load;
	logic                                 clr_run;
	logic [mad_pkg::WS_W-1:0]             w_cfg;
	logic [PW-1:0]                        pos_sum;
	logic [AW-1:0]                        old_pos;
	logic [mad_pkg::Y_W-1:0]              ram_rdata;
	mad_pkg::sample_t                     old_val;
	mad_pkg::wsum_t                       prod;
	logic [mad_pkg::NUM_W-1:0]            num_u;
	logic [mad_pkg::NUM_W-1:0]            mag;
	logic [mad_pkg::NUM_W-1:0]            rnd;
	logic [mad_pkg::DVR_W+1:0]            trial;
	logic                                 q_bit;
	logic [mad_pkg::DVR_W-1:0]            rem_nxt;
	logic [mad_pkg::Y_W-1:0]              quo;
	mad_pkg::dev_t                        q_dev;
	mad_pkg::dev_t                        dev_val;
	logic                                 count_it;

	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign in_acc    = in_valid && in_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign clr_run   = (cfg_acc && cfg_index == mad_pkg::CFG_WINDOW_SIZE) || (out_load && last_q);

	// clamp the window size into 1..MAX_WINDOW
	always_comb begin
		w_cfg = cfg_data;
		if (cfg_data == '0) begin
			w_cfg = mad_pkg::WS_W'(1);
		end else if (int'(cfg_data) > MAX_WINDOW) begin
			w_cfg = mad_pkg::WS_W'(MAX_WINDOW);
		end
	end

	// position of the sample leaving the window
	assign pos_sum = PW'(wr_pos_q) + MAX_P - PW'(w_eff_q);
	assign old_pos = (pos_sum >= MAX_P) ? AW'(pos_sum - MAX_P) : AW'(pos_sum);

	mad_ram #(
		.WIDTH(mad_pkg::Y_W),
		.DEPTH(MAX_WINDOW)
	) u_window (
		.clk    (clk),
		.wr_en  (state_q == S_MUL),
		.wr_addr(wr_pos_q),
		.wr_data(y_q),
		.rd_en  (in_acc),
		.rd_addr(old_pos),
		.rd_data(ram_rdata)
	);

	// entries not yet written in this run count as zero
	assign old_val = (scnt_q >= mad_pkg::CNT_W'(w_eff_q)) ? ram_rdata : '0;
	assign prod    = mad_pkg::SUM_W'(y_q) * mad_pkg::SUM_W'($signed({1'b0, w_eff_q}));

	assign num_u = num_q;
	assign mag   = num_q[mad_pkg::NUM_W-1] ? (mad_pkg::NUM_W'(0) - num_u) : num_u;
	assign rnd   = mag + mad_pkg::NUM_W'(w_eff_q >> 1);

	// one restoring step: the quotient bit shifts in at the bottom of the dividend
	assign trial   = {1'b0, rem_q, dvd_q[mad_pkg::DSUM_W-1]} - {2'b00, dvr_q};
	assign q_bit   = ~trial[mad_pkg::DVR_W+1];
	assign rem_nxt = q_bit ? trial[mad_pkg::DVR_W-1:0]
		: {rem_q[mad_pkg::DVR_W-2:0], dvd_q[mad_pkg::DSUM_W-1]};

	assign quo      = dvd_q[mad_pkg::Y_W-1:0];
	assign q_dev    = {1'b0, quo};
	assign dev_val  = (neg_q && !abs_q) ? (mad_pkg::DEV_W'(0) - q_dev) : q_dev;
	assign count_it = (abs_q || (!neg_q && quo != '0)) && (pc_q != mad_pkg::CNT_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			w_eff_q      <= mad_pkg::WS_W'(W_RESET_I);
			abs_q        <= 1'b1;
			wsum_q       <= '0;
			scnt_q       <= '0;
			dsum_q       <= '0;
			pc_q         <= '0;
			wr_pos_q     <= '0;
			cnt_q        <= '0;
			mean_phase_q <= 1'b0;
		end else begin
			if (cfg_acc) begin
				unique case (cfg_index)
					mad_pkg::CFG_WINDOW_SIZE: w_eff_q <= w_cfg;
					mad_pkg::CFG_ABSOLUTE_MODE: abs_q <= cfg_data[0];
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					wsum_q   <= wsum_q + mad_pkg::SUM_W'(y_q) - mad_pkg::SUM_W'(old_val);
					wr_pos_q <= (wr_pos_q == LAST_POS) ? '0 : wr_pos_q + 1'b1;
					state_q  <= S_PREP;
				end
				S_PREP: begin
					cnt_q        <= mad_pkg::DIV_CNT_W'(mad_pkg::DEV_ITER);
					mean_phase_q <= 1'b0;
					state_q      <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == mad_pkg::DIV_CNT_W'(1)) begin
						state_q <= mean_phase_q ? S_OUT : S_POST;
					end
				end
				S_POST: begin
					if (scnt_q != mad_pkg::CNT_MAX) begin
						scnt_q <= scnt_q + 1'b1;
					end
					if (count_it) begin
						dsum_q <= dsum_q + mad_pkg::DSUM_W'(quo);
						pc_q   <= pc_q + 1'b1;
					end
					state_q <= last_q ? S_MPREP : S_OUT;
				end
				S_MPREP: begin
					if (pc_q != '0) begin
						cnt_q        <= mad_pkg::DIV_CNT_W'(mad_pkg::MEAN_ITER);
						mean_phase_q <= 1'b1;
						state_q      <= S_DIV;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// drop the run at its end or on a new window size
			if (clr_run) begin
				wsum_q   <= '0;
				scnt_q   <= '0;
				dsum_q   <= '0;
				pc_q     <= '0;
				wr_pos_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					x_q    <= sample_x;
					y_q    <= sample_y;
					last_q <= last_sample;
					idx_q  <= scnt_q;
				end
			end
			S_MUL: begin
				num_q <= mad_pkg::NUM_W'(prod) - mad_pkg::NUM_W'(wsum_q);
			end
			S_PREP: begin
				neg_q <= num_q[mad_pkg::NUM_W-1];
				dvd_q <= {rnd, {PAD_W{1'b0}}};
				dvr_q <= mad_pkg::DVR_W'(w_eff_q);
				rem_q <= '0;
			end
			S_DIV: begin
				rem_q <= rem_nxt;
				dvd_q <= {dvd_q[mad_pkg::DSUM_W-2:0], q_bit};
			end
			S_POST: begin
				dev_q <= dev_val;
			end
			S_MPREP: begin
				dvd_q <= dsum_q + mad_pkg::DSUM_W'(pc_q >> 1);
				dvr_q <= pc_q;
				rem_q <= '0;
			end
			S_OUT: begin
				if (out_load) begin
					item_x_q         <= x_q;
					item_y_q         <= y_q;
					item_index_q     <= idx_q;
					deviation_q      <= dev_q;
					end_of_run_q     <= last_q;
					mean_deviation_q <= mean_phase_q ? mad_pkg::DEV_W'(quo) : '0;
					mean_valid_q     <= mean_phase_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign item_x         = item_x_q;
	assign item_y         = item_y_q;
	assign item_index     = item_index_q;
	assign deviation      = deviation_q;
	assign end_of_run     = end_of_run_q;
	assign mean_deviation = mean_deviation_q;
	assign mean_valid     = mean_valid_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == S_MUL)
		else $error("accepted transaction did not start the multiply step");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < dvr_q))
		else $error("divider remainder not below divisor");

	a_out_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result raised outside the final state");

	a_points_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= scnt_q)
		else $error("point count exceeds sample count");

	a_wr_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(wr_pos_q) < MAX_WINDOW)
		else $error("window write position out of range");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

	localparam int WIN_DEPTH   = 1024;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int DRAIN       = 150;
	localparam int SHORT_ITEMS = 24;

	typedef enum logic {ROW_SAMPLE, ROW_SETTING} row_kind_t;
	typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_style_t;

	typedef struct {
		logic [mad_pkg::X_W-1:0]   x;
		mad_pkg::sample_t          y;
		mad_pkg::count_t           index;
		mad_pkg::dev_t             dev;
		logic                      eor;
		mad_pkg::dev_t             mean;
		logic                      mvalid;
	} dev_record_t;

	typedef struct {
		row_kind_t                 kind;
		logic [mad_pkg::X_W-1:0]   x;
		logic [mad_pkg::Y_W-1:0]   y;
		logic                      fin;
		bit                        known;
		mad_pkg::dev_t             dev;
		mad_pkg::dev_t             mean;
		logic                      mvalid;
		bit                        wr_ws;
		logic [mad_pkg::WS_W-1:0]  ws;
		bit                        wr_mode;
		logic                      mode;
	} plan_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [mad_pkg::X_W-1:0]       sample_x = '0;
	logic signed [mad_pkg::Y_W-1:0] sample_y = '0;
	logic                 last_sample = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [mad_pkg::X_W-1:0]       item_x;
	logic signed [mad_pkg::Y_W-1:0] item_y;
	logic [mad_pkg::IDX_W-1:0]     item_index;
	logic signed [mad_pkg::DEV_W-1:0] deviation;
	logic                 end_of_run;
	logic signed [mad_pkg::DEV_W-1:0] mean_deviation;
	logic                 mean_valid;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [mad_pkg::CFG_IDX_W-1:0] cfg_index = mad_pkg::CFG_WINDOW_SIZE;
	logic [mad_pkg::WS_W-1:0]      cfg_data = '0;

	// window/run state mirrored from the block
	logic [mad_pkg::WS_W-1:0]      win_size_reg;
	logic                 abs_mode_reg;
	mad_pkg::sample_t     win_store [WIN_DEPTH];
	longint               win_sum;
	int unsigned          smp_count;
	logic [63:0]          dev_sum;
	int unsigned          pt_count;
	int unsigned          wr_pos;

	dev_record_t          deviation_records [$];
	plan_row_t            plan [$];

	int                   errors = 0;
	int                   cycles = 0;
	int                   samples_sent = 0;
	int                   runs_sent = 0;
	int                   writes_done = 0;
	int                   results_seen = 0;
	int                   means_valid = 0;
	int                   burst_left = 0;
	int                   rx_left = 0;
	rx_style_t            rx_style = RX_ALWAYS;
	logic [mad_pkg::Y_W-1:0]       prev_y = '0;

	moving_average_deviation_core #(
		.MAX_WINDOW(WIN_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_x(sample_x),
		.sample_y(sample_y),
		.last_sample(last_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.item_x(item_x),
		.item_y(item_y),
		.item_index(item_index),
		.deviation(deviation),
		.end_of_run(end_of_run),
		.mean_deviation(mean_deviation),
		.mean_valid(mean_valid),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles,
				deviation_records.size());
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic flag(input string msg);
		errors++;
		$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	function automatic void clear_run();
		for (int i = 0; i < WIN_DEPTH; i++)
			win_store[i] = '0;
		win_sum = 0;
		smp_count = 0;
		dev_sum = '0;
		pt_count = 0;
		wr_pos = 0;
	endfunction

	// Deviation of one sample from the mean of the window before it, then slide the window.
	function automatic dev_record_t advance_window(input logic [mad_pkg::X_W-1:0] x,
			input mad_pkg::sample_t y, input logic fin);
		dev_record_t r;
		longint w;
		longint num;
		longint mag;
		longint dev;
		logic [63:0] mean;
		int unsigned rd_pos;

		if (win_size_reg == 0)
			w = 1;
		else if (win_size_reg > WIN_DEPTH)
			w = WIN_DEPTH;
		else
			w = longint'(win_size_reg);

		num = longint'(y) * w - win_sum;
		mag = (num < 0) ? -num : num;
		dev = (mag + w / 2) / w;
		if (num < 0 && !abs_mode_reg)
			dev = -dev;

		if ((abs_mode_reg || dev > 0) && pt_count < mad_pkg::CNT_MAX) begin
			dev_sum += dev;
			pt_count++;
		end

		rd_pos = 32'((longint'(wr_pos) + WIN_DEPTH - w) % WIN_DEPTH);
		win_sum += longint'(y) - longint'(win_store[rd_pos]);
		win_store[wr_pos] = y;
		wr_pos = (wr_pos + 1) % WIN_DEPTH;

		r.x = x;
		r.y = y;
		r.index = mad_pkg::count_t'(smp_count);
		r.dev = dev[mad_pkg::DEV_W-1:0];
		r.eor = fin;
		r.mean = '0;
		r.mvalid = 1'b0;
		if (smp_count < mad_pkg::CNT_MAX)
			smp_count++;

		if (fin) begin
			if (pt_count != 0) begin
				mean = (dev_sum + 64'(pt_count / 2)) / 64'(pt_count);
				r.mean = mean[mad_pkg::DEV_W-1:0];
				r.mvalid = 1'b1;
			end
			clear_run();
		end
		return r;
	endfunction

	// Bursts of back-to-back transactions with gaps of assorted length between them.
	function automatic int next_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		burst_left = int'($urandom_range(0, 24));
		case ($urandom_range(0, 3))
			0: return int'($urandom_range(1, 3));
			1: return int'($urandom_range(4, 24));
			2: return int'($urandom_range(25, 64));
			default: return 0;
		endcase
	endfunction

	function automatic logic [mad_pkg::WS_W-1:0] random_window();
		case ($urandom_range(0, 5))
			0: return mad_pkg::WS_W'($urandom_range(0, 2));
			1: return mad_pkg::WS_W'($urandom_range(3, 8));
			2: return mad_pkg::WS_W'($urandom_range(9, 40));
			3: return mad_pkg::WS_W'($urandom_range(41, 1024));
			4: return mad_pkg::WS_W'($urandom_range(1025, 2047));
			default: return mad_pkg::WS_W'($urandom_range(1, 16));
		endcase
	endfunction

	function automatic logic [mad_pkg::Y_W-1:0] pick_y();
		logic [mad_pkg::Y_W-1:0] v;

		case ($urandom_range(0, 6))
			0, 1: v = $urandom;
			2: v = 32'($urandom_range(0, 'h7FFFF)) - 32'h40000;
			3: begin
				case ($urandom_range(0, 3))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = '0;
					default: v = '1;
				endcase
			end
			4: v = prev_y;
			default: v = prev_y + 32'($urandom_range(0, 'hFFFF)) - 32'h8000;
		endcase
		prev_y = v;
		return v;
	endfunction

	function automatic plan_row_t sample_row(input logic [mad_pkg::X_W-1:0] x,
			input logic [mad_pkg::Y_W-1:0] y, input logic fin);
		plan_row_t r;

		r.kind = ROW_SAMPLE;
		r.x = x;
		r.y = y;
		r.fin = fin;
		r.known = 1'b0;
		r.dev = '0;
		r.mean = '0;
		r.mvalid = 1'b0;
		r.wr_ws = 1'b0;
		r.ws = '0;
		r.wr_mode = 1'b0;
		r.mode = 1'b0;
		return r;
	endfunction

	function automatic plan_row_t known_row(input logic [mad_pkg::X_W-1:0] x,
			input logic [mad_pkg::Y_W-1:0] y, input logic fin, input mad_pkg::dev_t dev,
			input mad_pkg::dev_t mean, input logic mvalid);
		plan_row_t r;

		r = sample_row(x, y, fin);
		r.known = 1'b1;
		r.dev = dev;
		r.mean = mean;
		r.mvalid = mvalid;
		return r;
	endfunction

	function automatic plan_row_t setting_row(input bit wr_ws, input logic [mad_pkg::WS_W-1:0] ws,
			input bit wr_mode, input logic mode);
		plan_row_t r;

		r = sample_row('0, '0, 1'b0);
		r.kind = ROW_SETTING;
		r.wr_ws = wr_ws;
		r.ws = ws;
		r.wr_mode = wr_mode;
		r.mode = mode;
		return r;
	endfunction

	// Registers change only with nothing in flight; at least one write per call.
	task automatic set_config(input bit wr_ws, input logic [mad_pkg::WS_W-1:0] ws,
			input bit wr_mode, input logic mode);
		in_valid <= 1'b0;
		while (deviation_records.size() != 0)
			@(posedge clk);
		if (wr_ws) begin
			cfg_valid <= 1'b1;
			cfg_index <= mad_pkg::CFG_WINDOW_SIZE;
			cfg_data <= ws;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			win_size_reg = ws;
			clear_run();
			writes_done++;
		end
		if (wr_mode) begin
			cfg_valid <= 1'b1;
			cfg_index <= mad_pkg::CFG_ABSOLUTE_MODE;
			cfg_data <= {{(mad_pkg::WS_W-1){1'b0}}, mode};
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			abs_mode_reg = mode;
			writes_done++;
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic feed(input logic [mad_pkg::X_W-1:0] x, input logic [mad_pkg::Y_W-1:0] y,
			input logic fin, input bit known, input mad_pkg::dev_t kdev,
			input mad_pkg::dev_t kmean, input logic kmv);
		dev_record_t rec;
		int gap;

		gap = next_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_x <= x;
		sample_y <= y;
		last_sample <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		rec = advance_window(x, y, fin);
		if (known) begin
			rec.dev = kdev;
			rec.mean = kmean;
			rec.mvalid = kmv;
		end
		deviation_records.push_back(rec);
		samples_sent++;
		if (fin)
			runs_sent++;
	endtask

	// Receiver: check each transaction, then pick out_ready by the current stall style.
	always @(posedge clk) begin : rx
		dev_record_t want;

		if (rx_left == 0) begin
			rx_style = rx_style_t'($urandom_range(0, 3));
			rx_left = int'($urandom_range(20, 400));
		end
		rx_left--;

		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (deviation_records.size() == 0) begin
				flag($sformatf("result %0d arrived with no sample pending", results_seen));
			end else begin
				want = deviation_records.pop_front();
				if (want.mvalid)
					means_valid++;
				if (item_x !== want.x)
					flag($sformatf("result %0d item_x %h, want %h", results_seen, item_x, want.x));
				if (item_y !== want.y)
					flag($sformatf("result %0d item_y %h, want %h", results_seen, item_y, want.y));
				if (item_index !== want.index)
					flag($sformatf("result %0d item_index %0d, want %0d", results_seen,
						item_index, want.index));
				if (deviation !== want.dev)
					flag($sformatf("result %0d deviation %0d, want %0d", results_seen,
						deviation, want.dev));
				if (end_of_run !== want.eor)
					flag($sformatf("result %0d end_of_run %b, want %b", results_seen,
						end_of_run, want.eor));
				if (mean_deviation !== want.mean)
					flag($sformatf("result %0d mean_deviation %0d, want %0d", results_seen,
						mean_deviation, want.mean));
				if (mean_valid !== want.mvalid)
					flag($sformatf("result %0d mean_valid %b, want %b", results_seen,
						mean_valid, want.mvalid));
			end
		end

		case (rx_style)
			RX_ALWAYS:   out_ready <= 1'b1;
			RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
			RX_PERIODIC: out_ready <= (cycles % 7) < 3;
			RX_SPARSE:   out_ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	initial begin
		plan_row_t row;
		int seg;
		int n;
		int short_sent;
		int pick;
		logic fin;

		win_size_reg = mad_pkg::WS_W'(mad_pkg::WS_RESET_I);
		abs_mode_reg = 1'b1;
		clear_run();

		// reset defaults: window 16, absolute mode
		plan.push_back(known_row(32'h0000_0000, 32'h0000_0000, 1'b0, 33'sd0, 33'sd0, 1'b0));
		plan.push_back(known_row(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 33'sd2147483647, 33'sd0,
			1'b0));
		plan.push_back(sample_row(32'hA5A5_A5A5, 32'h8000_0000, 1'b0));
		plan.push_back(sample_row(32'h0000_0001, 32'h0001_0000, 1'b1));
		// one-sample run in absolute mode: a zero deviation still counts
		plan.push_back(known_row(32'h5A5A_5A5A, 32'h0000_0000, 1'b1, 33'sd0, 33'sd0, 1'b1));
		plan.push_back(setting_row(1'b0, '0, 1'b1, 1'b0));
		// signed mode: nothing positive in the run, so the mean is invalid
		plan.push_back(known_row(32'h0000_0002, 32'h0000_0000, 1'b1, 33'sd0, 33'sd0, 1'b0));
		plan.push_back(known_row(32'h0000_0003, 32'hFFFF_0000, 1'b0, -33'sd65536, 33'sd0, 1'b0));
		plan.push_back(sample_row(32'h0000_0004, 32'h0003_0000, 1'b0));
		plan.push_back(sample_row(32'h0000_0005, 32'h7FFF_FFFF, 1'b1));
		// zero window acts as one
		plan.push_back(setting_row(1'b1, 11'd0, 1'b0, 1'b0));
		plan.push_back(known_row(32'h0000_0006, 32'h0000_0005, 1'b0, 33'sd5, 33'sd0, 1'b0));
		plan.push_back(known_row(32'h0000_0007, 32'h0000_0003, 1'b0, -33'sd2, 33'sd0, 1'b0));
		// mode flip in the middle of a run
		plan.push_back(setting_row(1'b0, '0, 1'b1, 1'b1));
		plan.push_back(sample_row(32'h0000_0008, 32'h0000_0003, 1'b0));
		plan.push_back(sample_row(32'h0000_0009, 32'h8000_0000, 1'b1));
		// oversized window clamps to the store depth
		plan.push_back(setting_row(1'b1, 11'd2047, 1'b1, 1'b0));
		plan.push_back(sample_row(32'h1234_5678, 32'h1234_5678, 1'b0));
		plan.push_back(sample_row(32'h8765_4321, 32'hEDCB_A988, 1'b0));
		plan.push_back(sample_row(32'hDEAD_BEEF, 32'h0000_8000, 1'b1));
		plan.push_back(setting_row(1'b1, 11'd1024, 1'b1, 1'b1));
		plan.push_back(sample_row(32'hFFFF_0000, 32'h7FFF_FFFF, 1'b0));
		plan.push_back(sample_row(32'h0000_FFFF, 32'h7FFF_FFFF, 1'b1));
		// window of two: half-way cases round away from zero
		plan.push_back(setting_row(1'b1, 11'd2, 1'b1, 1'b0));
		plan.push_back(sample_row(32'h0000_000A, 32'h0000_0001, 1'b0));
		plan.push_back(sample_row(32'h0000_000B, 32'h0000_0000, 1'b0));
		plan.push_back(sample_row(32'h0000_000C, 32'hFFFF_FFFF, 1'b0));
		plan.push_back(sample_row(32'h0000_000D, 32'h0000_0004, 1'b1));
		plan.push_back(setting_row(1'b0, '0, 1'b1, 1'b1));
		plan.push_back(sample_row(32'h0000_000E, 32'h0000_0001, 1'b0));
		plan.push_back(sample_row(32'h0000_000F, 32'h0000_0000, 1'b1));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			row = plan[i];
			if (row.kind == ROW_SETTING)
				set_config(row.wr_ws, row.ws, row.wr_mode, row.mode);
			else
				feed(row.x, row.y, row.fin, row.known, row.dev, row.mean, row.mvalid);
		end

		// short segments; runs may span a mode change
		short_sent = 0;
		while (short_sent < SHORT_ITEMS) begin
			pick = int'($urandom_range(0, 3));
			set_config(pick != 1, random_window(), pick != 0, 1'($urandom_range(0, 1)));
			seg = int'($urandom_range(1, 8));
			for (int k = 0; k < seg; k++) begin
				fin = ($urandom_range(0, 9) == 0) || (k == seg - 1 && $urandom_range(0, 1) == 1);
				feed($urandom, pick_y(), fin, 1'b0, '0, '0, 1'b0);
				short_sent++;
			end
		end

		// one long run: a near-full window and a wrap of the store position
		set_config(1'b1, mad_pkg::WS_W'($urandom_range(1000, 1024)), 1'b1,
			1'($urandom_range(0, 1)));
		n = WIN_DEPTH + int'($urandom_range(2, 16));
		for (int k = 0; k < n; k++)
			feed($urandom, pick_y(), k == n - 1, 1'b0, '0, '0, 1'b0);

		in_valid <= 1'b0;
		while (deviation_records.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (deviation_records.size() != 0)
			flag($sformatf("%0d results never arrived", deviation_records.size()));

		$display("Sent %0d samples in %0d closed runs with %0d register writes.",
			samples_sent, runs_sent, writes_done);
		$display("Checked %0d results, %0d carrying a valid mean; %0d mismatches.",
			results_seen, means_valid, errors);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/mad_pkg.sv
rtl/core/mad_ram.sv
rtl/core/moving_average_deviation_core.sv
tb/testbench.sv
